// ===== rtl/nhp_pkg.sv =====
// ----------------------------------------------------------------------------
// nhp_pkg: shared types and constants of the NPDU header parser
// Parse phases, byte-kind codes, control-byte masks and the state and
// result records passed between the classifier and the top level.
// ----------------------------------------------------------------------------
package nhp_pkg;

	// Largest MAC address length accepted without a length error
	localparam logic [7:0] MAX_MAC_LEN = 8'd8;

	// Control byte flags
	localparam logic [7:0] CTL_NET = 8'h80;   // message type present
	localparam logic [7:0] CTL_DST = 8'h20;   // DNET/DLEN/DADR and hop count present
	localparam logic [7:0] CTL_SRC = 8'h08;   // SNET/SLEN/SADR present
	localparam logic [7:0] MSG_VENDOR = 8'h80; // vendor id follows the message type

	// Byte kind codes as seen on the result channel
	localparam logic [3:0] KIND_VER  = 4'd0;
	localparam logic [3:0] KIND_CTL  = 4'd1;
	localparam logic [3:0] KIND_DNH  = 4'd2;
	localparam logic [3:0] KIND_DNL  = 4'd3;
	localparam logic [3:0] KIND_DLEN = 4'd4;
	localparam logic [3:0] KIND_DADR = 4'd5;
	localparam logic [3:0] KIND_SNH  = 4'd6;
	localparam logic [3:0] KIND_SNL  = 4'd7;
	localparam logic [3:0] KIND_SLEN = 4'd8;
	localparam logic [3:0] KIND_SADR = 4'd9;
	localparam logic [3:0] KIND_HOP  = 4'd10;
	localparam logic [3:0] KIND_MSG  = 4'd11;
	localparam logic [3:0] KIND_VH   = 4'd12;
	localparam logic [3:0] KIND_VL   = 4'd13;
	localparam logic [3:0] KIND_PAY  = 4'd14;

	// Parse phase: the field expected for the next byte, one-hot
	typedef enum logic [14:0] {
		PH_VER  = 15'h0001,
		PH_CTL  = 15'h0002,
		PH_DNH  = 15'h0004,
		PH_DNL  = 15'h0008,
		PH_DLEN = 15'h0010,
		PH_DADR = 15'h0020,
		PH_SNH  = 15'h0040,
		PH_SNL  = 15'h0080,
		PH_SLEN = 15'h0100,
		PH_SADR = 15'h0200,
		PH_HOP  = 15'h0400,
		PH_MSG  = 15'h0800,
		PH_VH   = 15'h1000,
		PH_VL   = 15'h2000,
		PH_PAY  = 15'h4000
	} phase_t;

	// Parser state carried from byte to byte
	typedef struct packed {
		phase_t     phase;
		logic [7:0] ctl;    // last control byte
		logic [7:0] left;   // MAC bytes still to come
		logic [7:0] pos;    // offset of the next byte, saturating
	} parse_state_t;

	// Classification of one byte
	typedef struct packed {
		logic [3:0] kind;
		logic [7:0] value;
		logic [7:0] offset;
		logic       done;
		logic       len_err;
	} result_t;

	// Phase to byte-kind code
	function automatic logic [3:0] kind_of(input phase_t ph);
		logic [3:0] k;
		unique case (ph)
			PH_VER:  k = KIND_VER;
			PH_CTL:  k = KIND_CTL;
			PH_DNH:  k = KIND_DNH;
			PH_DNL:  k = KIND_DNL;
			PH_DLEN: k = KIND_DLEN;
			PH_DADR: k = KIND_DADR;
			PH_SNH:  k = KIND_SNH;
			PH_SNL:  k = KIND_SNL;
			PH_SLEN: k = KIND_SLEN;
			PH_SADR: k = KIND_SADR;
			PH_HOP:  k = KIND_HOP;
			PH_MSG:  k = KIND_MSG;
			PH_VH:   k = KIND_VH;
			PH_VL:   k = KIND_VL;
			default: k = KIND_PAY;
		endcase
		return k;
	endfunction

endpackage

// ===== rtl/npdu_header_parser.sv =====
// ----------------------------------------------------------------------------
// npdu_header_parser: network-layer header classifier, one byte per cycle unless m_tready stalls
// Tags every packet byte with the NPDU header field it belongs to.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_*: one packet byte per word in s_tdata; s_tuser is high on
//   the first byte (version) of a packet and restarts parsing there.
//   Output stream m_*: one word per input byte. m_tuser holds the byte kind,
//   m_tlast marks the last header byte, m_tdata carries the byte, its offset
//   in the packet (saturating at 255) and the MAC length error flag.
//   Path: an accepted byte is registered into the input stage, and its result
//   is registered into the output register, which presents it. Throughput is
//   one byte per cycle while m_tready is high; the classifier between the
//   input and output registers is combinational.
//   Reset clears both stages and returns the parser to expecting a version
//   byte at offset zero. When m_tready is low the output word holds, the
//   input stage fills, and s_tready drops once both are occupied.
// ----------------------------------------------------------------------------
module npdu_header_parser (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tuser,   // [0] frame_start
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [7:0] byte_value, [15:8] header_offset,
	                               // [16] length_error, [23:17] zero
	output logic [3:0]  m_tuser,   // [3:0] byte_kind
	output logic        m_tlast    // header_done
);

	logic                  valid_s1;
	logic [7:0]            byte_s1;
	logic                  start_s1;
	logic                  valid_s2;
	nhp_pkg::result_t      res_s2;
	nhp_pkg::parse_state_t state_q;
	nhp_pkg::parse_state_t state_next;
	nhp_pkg::result_t      res_next;
	logic                  adv_s2;
	logic                  in_fire;

	assign adv_s2   = !valid_s2 || m_tready;
	assign s_tready = !valid_s1 || adv_s2;
	assign in_fire  = s_tvalid && s_tready;

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			byte_s1  <= s_tdata;
			start_s1 <= s_tuser;
		end
	end

	// classifier
	nhp_classify u_classify (
		.st          (state_q),
		.data_byte   (byte_s1),
		.frame_start (start_s1),
		.nst         (state_next),
		.res         (res_next)
	);

	// parser state advances when the input stage hands a byte on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase <= nhp_pkg::PH_VER;
			state_q.ctl   <= 8'd0;
			state_q.left  <= 8'd0;
			state_q.pos   <= 8'd0;
		end else if (valid_s1 && adv_s2) begin
			state_q <= state_next;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && adv_s2) begin
			res_s2 <= res_next;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {7'd0, res_s2.len_err, res_s2.offset, res_s2.value};
	assign m_tuser  = res_s2.kind;
	assign m_tlast  = res_s2.done;

	// checks
	a_done_not_payload: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tuser != nhp_pkg::KIND_PAY)
		else $error("header end marked on a payload byte");

	a_len_err_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[16] |->
			(m_tuser == nhp_pkg::KIND_DLEN || m_tuser == nhp_pkg::KIND_SLEN))
		else $error("length error on a byte that is not a length field");

	a_version_offset: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == nhp_pkg::KIND_VER |-> m_tdata[15:8] == 8'd0)
		else $error("version byte not at offset zero");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && valid_s2 && !m_tready |=> valid_s1 && $stable(byte_s1))
		else $error("input stage lost a byte while output stalled");

endmodule

// ===== rtl/nhp_classify.sv =====
// ----------------------------------------------------------------------------
// nhp_classify: per-byte header field classifier
// Given the parser state and one packet byte, tags the byte with its header
// field and works out the state for the following byte.
// ----------------------------------------------------------------------------
module nhp_classify (
	input  nhp_pkg::parse_state_t st,
	input  logic [7:0]            data_byte,
	input  logic                  frame_start,
	output nhp_pkg::parse_state_t nst,
	output nhp_pkg::result_t      res
);

	nhp_pkg::phase_t ph;
	nhp_pkg::phase_t next_ph;
	nhp_pkg::phase_t after_hop;
	nhp_pkg::phase_t after_src;
	nhp_pkg::phase_t after_dst;
	logic [7:0]      off;
	logic [7:0]      ctl;
	logic [7:0]      left_dec;
	logic [7:0]      left_next;
	logic [3:0]      kind;
	logic            len_err;

	// frame_start restarts the packet at the version byte
	assign ph  = frame_start ? nhp_pkg::PH_VER : st.phase;
	assign off = frame_start ? 8'd0 : st.pos;

	// control byte in effect: the current byte when it is the control byte
	assign ctl = (ph == nhp_pkg::PH_CTL) ? data_byte : st.ctl;

	// fields that follow a skipped or finished section
	assign after_hop = ((ctl & nhp_pkg::CTL_NET) != 8'd0) ? nhp_pkg::PH_MSG : nhp_pkg::PH_PAY;
	assign after_src = ((ctl & nhp_pkg::CTL_DST) != 8'd0) ? nhp_pkg::PH_HOP : after_hop;
	assign after_dst = ((ctl & nhp_pkg::CTL_SRC) != 8'd0) ? nhp_pkg::PH_SNH : after_src;

	assign left_dec = (st.left != 8'd0) ? st.left - 8'd1 : 8'd0;

	// next phase and MAC byte count
	always_comb begin
		next_ph   = nhp_pkg::PH_PAY;
		left_next = st.left;
		len_err   = 1'b0;
		unique case (ph)
			nhp_pkg::PH_VER:  next_ph = nhp_pkg::PH_CTL;
			nhp_pkg::PH_CTL:  next_ph = ((ctl & nhp_pkg::CTL_DST) != 8'd0) ?
				nhp_pkg::PH_DNH : after_dst;
			nhp_pkg::PH_DNH:  next_ph = nhp_pkg::PH_DNL;
			nhp_pkg::PH_DNL:  next_ph = nhp_pkg::PH_DLEN;
			nhp_pkg::PH_DLEN: begin
				left_next = data_byte;
				len_err   = data_byte > nhp_pkg::MAX_MAC_LEN;
				next_ph   = (data_byte != 8'd0) ? nhp_pkg::PH_DADR : after_dst;
			end
			nhp_pkg::PH_DADR: begin
				left_next = left_dec;
				next_ph   = (left_dec != 8'd0) ? nhp_pkg::PH_DADR : after_dst;
			end
			nhp_pkg::PH_SNH:  next_ph = nhp_pkg::PH_SNL;
			nhp_pkg::PH_SNL:  next_ph = nhp_pkg::PH_SLEN;
			nhp_pkg::PH_SLEN: begin
				left_next = data_byte;
				len_err   = data_byte > nhp_pkg::MAX_MAC_LEN;
				next_ph   = (data_byte != 8'd0) ? nhp_pkg::PH_SADR : after_src;
			end
			nhp_pkg::PH_SADR: begin
				left_next = left_dec;
				next_ph   = (left_dec != 8'd0) ? nhp_pkg::PH_SADR : after_src;
			end
			nhp_pkg::PH_HOP:  next_ph = after_hop;
			nhp_pkg::PH_MSG:  next_ph = ((data_byte & nhp_pkg::MSG_VENDOR) != 8'd0) ?
				nhp_pkg::PH_VH : nhp_pkg::PH_PAY;
			nhp_pkg::PH_VH:   next_ph = nhp_pkg::PH_VL;
			nhp_pkg::PH_VL:   next_ph = nhp_pkg::PH_PAY;
			default:          next_ph = nhp_pkg::PH_PAY;
		endcase
	end

	assign kind = nhp_pkg::kind_of(ph);

	// state for the next byte
	assign nst.phase = next_ph;
	assign nst.ctl   = ctl;
	assign nst.left  = left_next;
	assign nst.pos   = (off != 8'hFF) ? off + 8'd1 : 8'hFF;

	// result word
	assign res.kind    = kind;
	assign res.value   = data_byte;
	assign res.offset  = off;
	assign res.done    = (kind != nhp_pkg::KIND_PAY) && (next_ph == nhp_pkg::PH_PAY);
	assign res.len_err = len_err;

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the NPDU header parser
// Feeds packets byte by byte on the input stream and predicts the tag of each
// byte (kind, offset, header end, length error) with a local parser model.
// Each output word is compared with the oldest prediction. Directed packets
// hit the special cases, then random packets, both well-formed and broken,
// run under bursty input traffic and a stalling receiver.
// ----------------------------------------------------------------------------
module testbench;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata  = 8'h00;
	logic        s_tuser  = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;
	logic [3:0]  m_tuser;
	logic        m_tlast;

	npdu_header_parser u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always #2 clk = ~clk;

	// Parser model state
	logic [3:0] want_kind = nhp_pkg::KIND_VER;   // kind of the next byte
	logic [7:0] ctl_copy  = 8'h00;
	logic [7:0] mac_left  = 8'h00;
	logic [7:0] next_pos  = 8'h00;

	nhp_pkg::result_t pending_tags[$];
	int unsigned err_count   = 0;
	int unsigned bytes_sent  = 0;
	int unsigned words_seen  = 0;
	int unsigned header_ends = 0;
	int unsigned len_errors  = 0;
	int unsigned saturated   = 0;
	int unsigned burst_left  = 0;

	// Field order after each optional group
	function automatic logic [3:0] past_hop();
		return ((ctl_copy & nhp_pkg::CTL_NET) != 8'd0) ? nhp_pkg::KIND_MSG : nhp_pkg::KIND_PAY;
	endfunction

	function automatic logic [3:0] past_src();
		return ((ctl_copy & nhp_pkg::CTL_DST) != 8'd0) ? nhp_pkg::KIND_HOP : past_hop();
	endfunction

	function automatic logic [3:0] past_dst();
		return ((ctl_copy & nhp_pkg::CTL_SRC) != 8'd0) ? nhp_pkg::KIND_SNH : past_src();
	endfunction

	// Tag one accepted byte and queue the tag
	task automatic classify_byte(input logic [7:0] b, input logic start);
		nhp_pkg::result_t r;
		logic [3:0] cur;
		logic [3:0] nxt;
		logic [7:0] off;
		off = start ? 8'd0 : next_pos;
		cur = start ? nhp_pkg::KIND_VER : want_kind;
		nxt = nhp_pkg::KIND_PAY;
		r.len_err = 1'b0;
		case (cur)
			nhp_pkg::KIND_VER: nxt = nhp_pkg::KIND_CTL;
			nhp_pkg::KIND_CTL: begin
				ctl_copy = b;
				nxt = ((b & nhp_pkg::CTL_DST) != 8'd0) ? nhp_pkg::KIND_DNH : past_dst();
			end
			nhp_pkg::KIND_DNH: nxt = nhp_pkg::KIND_DNL;
			nhp_pkg::KIND_DNL: nxt = nhp_pkg::KIND_DLEN;
			nhp_pkg::KIND_DLEN: begin
				mac_left = b;
				r.len_err = (b > nhp_pkg::MAX_MAC_LEN);
				nxt = (b != 8'd0) ? nhp_pkg::KIND_DADR : past_dst();
			end
			nhp_pkg::KIND_DADR: begin
				if (mac_left != 8'd0)
					mac_left = mac_left - 8'd1;
				nxt = (mac_left != 8'd0) ? nhp_pkg::KIND_DADR : past_dst();
			end
			nhp_pkg::KIND_SNH: nxt = nhp_pkg::KIND_SNL;
			nhp_pkg::KIND_SNL: nxt = nhp_pkg::KIND_SLEN;
			nhp_pkg::KIND_SLEN: begin
				mac_left = b;
				r.len_err = (b > nhp_pkg::MAX_MAC_LEN);
				nxt = (b != 8'd0) ? nhp_pkg::KIND_SADR : past_src();
			end
			nhp_pkg::KIND_SADR: begin
				if (mac_left != 8'd0)
					mac_left = mac_left - 8'd1;
				nxt = (mac_left != 8'd0) ? nhp_pkg::KIND_SADR : past_src();
			end
			nhp_pkg::KIND_HOP: nxt = past_hop();
			nhp_pkg::KIND_MSG: nxt = ((b & nhp_pkg::MSG_VENDOR) != 8'd0) ?
				nhp_pkg::KIND_VH : nhp_pkg::KIND_PAY;
			nhp_pkg::KIND_VH:  nxt = nhp_pkg::KIND_VL;
			nhp_pkg::KIND_VL:  nxt = nhp_pkg::KIND_PAY;
			default: begin
				cur = nhp_pkg::KIND_PAY;
				nxt = nhp_pkg::KIND_PAY;
			end
		endcase
		r.kind   = cur;
		r.value  = b;
		r.offset = off;
		r.done   = (cur != nhp_pkg::KIND_PAY) && (nxt == nhp_pkg::KIND_PAY);
		want_kind = nxt;
		next_pos  = (off == 8'hFF) ? off : off + 8'd1;
		pending_tags.push_back(r);
	endtask

	task automatic report_error(input string msg);
		err_count++;
		if (err_count <= 40)
			$display("[%0t] ERROR: %s", $realtime, msg);
	endtask

	// Send one byte; bursts of random length with random gaps between them
	task automatic send_byte(input logic [7:0] b, input logic start);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
			burst_left = $urandom_range(1, 40);
			if (gap > 0) begin
				@(negedge clk);
				s_tvalid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tuser  <= start;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		classify_byte(b, start);
		bytes_sent++;
	endtask

	// Sender holds off until every outstanding word is back
	task automatic drain_results();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_tags.size() != 0) @(posedge clk);
	endtask

	// Output check: compare each accepted word with the oldest tag
	always @(posedge clk) begin
		nhp_pkg::result_t t;
		if (arst_n && m_tvalid && m_tready) begin
			words_seen++;
			if (pending_tags.size() == 0) begin
				report_error($sformatf("word with no tag pending: kind %0d byte %02h",
					m_tuser, m_tdata[7:0]));
			end else begin
				t = pending_tags.pop_front();
				if (m_tuser !== t.kind)
					report_error($sformatf("word %0d kind %0d, want %0d",
						words_seen, m_tuser, t.kind));
				if (m_tdata[7:0] !== t.value)
					report_error($sformatf("word %0d byte %02h, want %02h",
						words_seen, m_tdata[7:0], t.value));
				if (m_tdata[15:8] !== t.offset)
					report_error($sformatf("word %0d offset %0d, want %0d",
						words_seen, m_tdata[15:8], t.offset));
				if (m_tdata[16] !== t.len_err)
					report_error($sformatf("word %0d length error %b, want %b",
						words_seen, m_tdata[16], t.len_err));
				if (m_tdata[23:17] !== 7'd0)
					report_error($sformatf("word %0d pad bits %h not zero",
						words_seen, m_tdata[23:17]));
				if (m_tlast !== t.done)
					report_error($sformatf("word %0d header end %b, want %b",
						words_seen, m_tlast, t.done));
				header_ends += t.done;
				len_errors  += t.len_err;
				if (t.offset == 8'hFF)
					saturated++;
			end
		end
	end

	// Receiver: windows of free flow, light, patterned and heavy stalls
	int unsigned      ready_mode = 0;
	int unsigned      ready_left = 0;
	logic      [15:0] ready_mask = 16'hFFFF;
	always @(negedge clk) begin
		if (ready_left == 0) begin
			ready_mode = $urandom_range(0, 3);
			ready_left = $urandom_range(8, 80);
			ready_mask = 16'($urandom_range(1, 16'hFFFF));
		end
		ready_left--;
		ready_mask = {ready_mask[14:0], ready_mask[15]};
		case (ready_mode)
			0: m_tready <= 1'b1;
			1: m_tready <= ($urandom_range(0, 3) != 0);
			2: m_tready <= ready_mask[0];
			default: m_tready <= ($urandom_range(0, 3) == 0);
		endcase
	end

	// No frame start after reset: first byte is still the version;
	// a control byte with no field flags ends the header
	task automatic test_after_reset();
		send_byte(8'h00, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
	endtask

	// Every field: all control bits set, zero DLEN, SLEN over the limit,
	// message type with the vendor id, then payload
	task automatic test_all_fields();
		send_byte(8'hFF, 1'b1);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'hA5, 1'b0);
		send_byte(8'h5A, 1'b0);
		send_byte(nhp_pkg::MAX_MAC_LEN + 8'd1, 1'b0);
		for (int i = 0; i <= nhp_pkg::MAX_MAC_LEN; i++)
			send_byte(8'(i * 37), 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(nhp_pkg::MSG_VENDOR, 1'b0);
		send_byte(8'h12, 1'b0);
		send_byte(8'h34, 1'b0);
		send_byte(8'h00, 1'b0);
	endtask

	// Frame start in mid-packet abandons the packet; message type without vendor
	task automatic test_restart();
		send_byte(8'h01, 1'b1);
		send_byte(nhp_pkg::CTL_DST, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h01, 1'b1);
		send_byte(nhp_pkg::CTL_NET, 1'b0);
		send_byte(8'h7F, 1'b0);
	endtask

	// Long payload so the offset saturates
	task automatic test_long_frame();
		send_byte(8'h01, 1'b1);
		send_byte(8'h00, 1'b0);
		for (int i = 0; i < 300; i++)
			send_byte(8'($urandom_range(0, 255)), 1'b0);
	endtask

	function automatic logic [7:0] pick_mac_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return 8'($urandom_range(0, nhp_pkg::MAX_MAC_LEN));
		if (r < 98)
			return 8'($urandom_range(nhp_pkg::MAX_MAC_LEN + 1, nhp_pkg::MAX_MAC_LEN + 4));
		return 8'($urandom_range(nhp_pkg::MAX_MAC_LEN + 1, 255));
	endfunction

	// Random packets, mostly well formed, some cut short, some noise
	task automatic test_random_packets(input int unsigned n_bytes);
		logic [7:0]  pkt[$];
		logic [7:0]  ctl;
		logic [7:0]  len;
		logic [7:0]  msg;
		int unsigned stop_at;
		stop_at = bytes_sent + n_bytes;
		while (bytes_sent < stop_at) begin
			if ($urandom_range(0, 19) == 0) begin
				repeat ($urandom_range(1, 5))
					send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
			end else begin
				pkt.delete();
				ctl = 8'($urandom_range(0, 255));
				pkt.push_back(8'($urandom_range(0, 255)));
				pkt.push_back(ctl);
				if ((ctl & nhp_pkg::CTL_DST) != 8'd0) begin
					pkt.push_back(8'($urandom_range(0, 255)));
					pkt.push_back(8'($urandom_range(0, 255)));
					len = pick_mac_len();
					pkt.push_back(len);
					repeat (len) pkt.push_back(8'($urandom_range(0, 255)));
				end
				if ((ctl & nhp_pkg::CTL_SRC) != 8'd0) begin
					pkt.push_back(8'($urandom_range(0, 255)));
					pkt.push_back(8'($urandom_range(0, 255)));
					len = pick_mac_len();
					pkt.push_back(len);
					repeat (len) pkt.push_back(8'($urandom_range(0, 255)));
				end
				if ((ctl & nhp_pkg::CTL_DST) != 8'd0)
					pkt.push_back(8'($urandom_range(0, 255)));
				if ((ctl & nhp_pkg::CTL_NET) != 8'd0) begin
					msg = 8'($urandom_range(0, 255));
					pkt.push_back(msg);
					if ((msg & nhp_pkg::MSG_VENDOR) != 8'd0) begin
						pkt.push_back(8'($urandom_range(0, 255)));
						pkt.push_back(8'($urandom_range(0, 255)));
					end
				end
				repeat ($urandom_range(0, 6)) pkt.push_back(8'($urandom_range(0, 255)));
				// broken packet: cut short, next frame start restarts parsing
				if ($urandom_range(0, 9) == 0)
					pkt = pkt[0:$urandom_range(0, pkt.size() - 1)];
				foreach (pkt[i])
					send_byte(pkt[i], i == 0);
			end
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_after_reset();
		test_all_fields();
		drain_results();
		test_restart();
		test_long_frame();
		drain_results();
		test_random_packets(600);
		drain_results();
		repeat (10) @(posedge clk);

		$display("Covered %0d bytes, %0d header ends, %0d length errors,",
			bytes_sent, header_ends, len_errors);
		$display("%0d saturated offsets, %0d output words checked.", saturated, words_seen);
		if (err_count == 0) begin
			$display("testbench: clean");
		end else begin
			$display("%0d mismatches", err_count);
			$display("testbench: errors");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#2000000;
		$display("Timeout with %0d words outstanding", pending_tags.size());
		$display("testbench: errors");
		$finish;
	end

endmodule
